// ----- design/alr_pkg.sv -----
// shared types, constants and byte class functions for the autolink recognizer
package alr_pkg;

  // length limits and counter width
  localparam int unsigned SCHEME_MAX = 32;
  localparam int unsigned DOMAIN_MAX = 63;
  localparam int unsigned CNT_W      = 7;

  // byte codes that the recognizer looks for
  localparam logic [7:0] CH_CTRL_MAX = 8'h1f;
  localparam logic [7:0] CH_DEL      = 8'h7f;
  localparam logic [7:0] CH_AT       = 8'h40;
  localparam logic [7:0] CH_GT       = 8'h3e;
  localparam logic [7:0] CH_LT       = 8'h3c;
  localparam logic [7:0] CH_COLON    = 8'h3a;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DOT      = 8'h2e;
  localparam logic [7:0] CH_DASH     = 8'h2d;
  localparam logic [7:0] CH_PLUS     = 8'h2b;

  // verdict codes
  localparam logic [1:0] V_PENDING = 2'd0;
  localparam logic [1:0] V_URL     = 2'd1;
  localparam logic [1:0] V_EMAIL   = 2'd2;
  localparam logic [1:0] V_REJECT  = 2'd3;

  // recognizer phase, one-hot
  typedef enum logic [8:0] {
    PH_IDLE         = 9'b000000001,
    PH_OPEN         = 9'b000000010,
    PH_SCHEME_FIRST = 9'b000000100,
    PH_SCHEME_IN    = 9'b000001000,
    PH_URL          = 9'b000010000,
    PH_ATEXT        = 9'b000100000,
    PH_AT_OR_DOT    = 9'b001000000,
    PH_LABEL        = 9'b010000000,
    PH_VALUE        = 9'b100000000
  } phase_t;

  // outcome of one byte step
  typedef struct packed {
    phase_t             phase;
    logic [CNT_W-1:0]   run_cnt;
    logic [1:0]         verdict;
  } step_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_scheme(input logic [7:0] c);
    return c == CH_PLUS || c == CH_DASH || c == CH_DOT || is_alnum(c);
  endfunction

  function automatic logic is_atext(input logic [7:0] c);
    return (c >= 8'h23 && c <= 8'h27) || c == 8'h2a || c == CH_PLUS ||
           (c >= CH_DASH && c <= 8'h39) || c == 8'h3d || c == 8'h3f ||
           (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h5e && c <= 8'h7e);
  endfunction

endpackage

// ----- design/alr_step.sv -----
// next phase, run count and verdict for one byte
module alr_step (
  input  alr_pkg::phase_t            phase_i,
  input  logic [alr_pkg::CNT_W-1:0]  run_cnt_i,
  input  logic                       enable_i,
  input  logic [7:0]                 byte_i,
  input  logic                       end_i,
  output alr_pkg::step_t             step_o
);

  localparam logic [alr_pkg::CNT_W-1:0] SCH_LIM = alr_pkg::CNT_W'(alr_pkg::SCHEME_MAX);
  localparam logic [alr_pkg::CNT_W-1:0] DOM_LIM = alr_pkg::CNT_W'(alr_pkg::DOMAIN_MAX);
  localparam logic [alr_pkg::CNT_W-1:0] CNT_ONE = alr_pkg::CNT_W'(1);

  alr_pkg::step_t rej;
  alr_pkg::step_t atx;
  alr_pkg::step_t val;
  alr_pkg::step_t sch;
  logic [alr_pkg::CNT_W-1:0] sch_cnt;

  // rejection: back to idle with a clear count
  assign rej = '{phase: alr_pkg::PH_IDLE, run_cnt: '0, verdict: alr_pkg::V_REJECT};

  // email local part, count kept
  always_comb begin
    if (end_i) begin
      atx = rej;
    end else if (byte_i == alr_pkg::CH_AT) begin
      atx = '{phase: alr_pkg::PH_AT_OR_DOT, run_cnt: run_cnt_i, verdict: alr_pkg::V_PENDING};
    end else if (alr_pkg::is_atext(byte_i)) begin
      atx = '{phase: alr_pkg::PH_ATEXT, run_cnt: run_cnt_i, verdict: alr_pkg::V_PENDING};
    end else begin
      atx = rej;
    end
  end

  // domain label byte with length limit
  always_comb begin
    if (!end_i && (byte_i == alr_pkg::CH_DASH || alr_pkg::is_alnum(byte_i)) &&
        run_cnt_i < DOM_LIM) begin
      val.phase   = (byte_i == alr_pkg::CH_DASH) ? alr_pkg::PH_VALUE : alr_pkg::PH_LABEL;
      val.run_cnt = alr_pkg::CNT_W'(run_cnt_i + CNT_ONE);
      val.verdict = alr_pkg::V_PENDING;
    end else begin
      val = rej;
    end
  end

  // scheme body; the first scheme byte enters with a count of one
  assign sch_cnt = (phase_i == alr_pkg::PH_SCHEME_FIRST) ? CNT_ONE : run_cnt_i;

  always_comb begin
    if (!end_i && byte_i == alr_pkg::CH_COLON) begin
      sch = '{phase: alr_pkg::PH_URL, run_cnt: '0, verdict: alr_pkg::V_PENDING};
    end else if (!end_i && alr_pkg::is_scheme(byte_i) && sch_cnt < SCH_LIM) begin
      sch = '{phase: alr_pkg::PH_SCHEME_IN, run_cnt: alr_pkg::CNT_W'(sch_cnt + CNT_ONE),
              verdict: alr_pkg::V_PENDING};
    end else begin
      // scheme failed: fall back to atext with the count cleared
      sch = atx;
      if (atx.verdict != alr_pkg::V_REJECT) begin
        sch.run_cnt = '0;
      end
    end
  end

  // phase dispatch
  always_comb begin
    step_o = rej;
    unique case (phase_i)
      alr_pkg::PH_OPEN: begin
        if (!end_i && alr_pkg::is_alpha(byte_i)) begin
          step_o = '{phase: alr_pkg::PH_SCHEME_FIRST, run_cnt: run_cnt_i,
                     verdict: alr_pkg::V_PENDING};
        end else if (!end_i && byte_i == alr_pkg::CH_AT) begin
          step_o = rej;
        end else begin
          step_o = atx;
        end
      end
      alr_pkg::PH_SCHEME_FIRST: begin
        if (!end_i && alr_pkg::is_scheme(byte_i)) begin
          step_o = sch;
        end else begin
          step_o = atx;
        end
      end
      alr_pkg::PH_SCHEME_IN: begin
        step_o = sch;
      end
      alr_pkg::PH_URL: begin
        if (!end_i && byte_i == alr_pkg::CH_GT) begin
          step_o = '{phase: alr_pkg::PH_IDLE, run_cnt: '0, verdict: alr_pkg::V_URL};
        end else if (end_i || byte_i <= alr_pkg::CH_CTRL_MAX || byte_i == alr_pkg::CH_SPACE ||
                     byte_i == alr_pkg::CH_LT || byte_i == alr_pkg::CH_DEL) begin
          step_o = rej;
        end else begin
          step_o = '{phase: alr_pkg::PH_URL, run_cnt: run_cnt_i, verdict: alr_pkg::V_PENDING};
        end
      end
      alr_pkg::PH_ATEXT: begin
        step_o = atx;
      end
      alr_pkg::PH_AT_OR_DOT: begin
        if (!end_i && alr_pkg::is_alnum(byte_i)) begin
          step_o = val;
        end else begin
          step_o = rej;
        end
      end
      alr_pkg::PH_LABEL: begin
        if (!end_i && byte_i == alr_pkg::CH_DOT) begin
          step_o = '{phase: alr_pkg::PH_AT_OR_DOT, run_cnt: '0, verdict: alr_pkg::V_PENDING};
        end else if (!end_i && byte_i == alr_pkg::CH_GT) begin
          step_o = '{phase: alr_pkg::PH_IDLE, run_cnt: '0, verdict: alr_pkg::V_EMAIL};
        end else begin
          step_o = val;
        end
      end
      alr_pkg::PH_VALUE: begin
        step_o = val;
      end
      default: begin
        // idle, and any unexpected code, waits for the opening bracket
        if (enable_i && !end_i && byte_i == alr_pkg::CH_LT) begin
          step_o = '{phase: alr_pkg::PH_OPEN, run_cnt: '0, verdict: alr_pkg::V_PENDING};
        end else begin
          step_o = rej;
        end
      end
    endcase
  end

endmodule

// ----- design/autolink_recognizer.sv -----
// top level of the angle-bracket autolink recognizer
// a word goes from the input register on to the result register
// throughput: one word per cycle while out_stall is low; the phase
//   step between the registers is the only loop, and combinational
// reset: rst_n is synchronous, active low; clears both pipeline valids,
//   returns the phase to idle with a zero count and sets enable to one
module autolink_recognizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_marker,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_verdict,
  output logic       out_consumed
);

  logic                       enable_r;
  logic                       in_vld_r;
  logic [7:0]                 in_byte_r;
  logic                       in_end_r;
  alr_pkg::phase_t            phase_r;
  logic [alr_pkg::CNT_W-1:0]  run_cnt_r;
  logic                       out_vld_r;
  logic [1:0]                 out_verdict_r;
  logic                       out_consumed_r;
  logic                       adv;
  logic                       in_take;
  alr_pkg::step_t             step;

  // the held word moves on when the result register is free or draining
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (cfg_wr_en) begin
      enable_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_data_byte;
      in_end_r  <= in_end_marker;
    end
  end

  alr_step u_step (
    .phase_i   (phase_r),
    .run_cnt_i (run_cnt_r),
    .enable_i  (enable_r),
    .byte_i    (in_byte_r),
    .end_i     (in_end_r),
    .step_o    (step)
  );

  // recognizer state advances once per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= alr_pkg::PH_IDLE;
      run_cnt_r <= '0;
    end else if (adv) begin
      phase_r   <= step.phase;
      run_cnt_r <= step.run_cnt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_verdict_r  <= step.verdict;
      out_consumed_r <= (step.verdict != alr_pkg::V_REJECT);
    end
  end

  assign out_valid    = out_vld_r;
  assign out_verdict  = out_verdict_r;
  assign out_consumed = out_consumed_r;

  // a stalled input word is still held next cycle
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> in_vld_r)
    else $error("held input word lost");

  // an accepted autolink always returns the phase to idle with zero count
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (step.verdict == alr_pkg::V_URL || step.verdict == alr_pkg::V_EMAIL))
      |=> (phase_r == alr_pkg::PH_IDLE && run_cnt_r == '0))
    else $error("phase not idle after acceptance");

  // a rejected word is never marked consumed
  a_reject_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_consumed_r == (out_verdict_r != alr_pkg::V_REJECT)))
    else $error("consumed flag disagrees with verdict");

  // the run count stays within the longer of the two limits
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (run_cnt_r <= alr_pkg::CNT_W'(alr_pkg::SCHEME_MAX) ||
     run_cnt_r <= alr_pkg::CNT_W'(alr_pkg::DOMAIN_MAX)))
    else $error("run count out of range");

endmodule
